// ===== hw/rtl/bra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;
  localparam int NBITS     = 1024;
  localparam int IDX_W     = $clog2(NBITS);
  localparam int LEN_W     = IDX_W + 1;
  localparam int WORD_W    = 32;
  localparam int WORDS     = NBITS / WORD_W;
  localparam int WADDR_W   = $clog2(WORDS);
  localparam int WBIT_W    = $clog2(WORD_W);
  localparam int QDEPTH    = 2;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(NBITS);

  localparam logic [2:0] CMD_GET   = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_UNSET = 3'd2;
  localparam logic [2:0] CMD_FILL  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_ALLOC = 3'd5;
  localparam logic [2:0] CMD_NOP   = 3'd6;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    logic [LEN_W-1:0] count;
    logic [3:0]       align;
  } op_t;

  typedef struct packed {
    logic             bit_value;
    logic [IDX_W-1:0] alloc_index;
    logic             found;
  } res_t;
endpackage

// ===== hw/rtl/bra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_front
// Accept requests, clamp ranges and queue classified operations.
// ----------------------------------------------------------------------------
module bra_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_cmd,
  input  logic [bra_pkg::IDX_W-1:0] in_bit_index,
  input  logic [bra_pkg::LEN_W-1:0] in_range_end,
  input  logic [bra_pkg::LEN_W-1:0] in_run_count,
  input  logic [3:0]                in_align_log2,
  input  logic [bra_pkg::LEN_W-1:0] eff_len,
  output logic                      op_valid,
  input  logic                      op_ready,
  output bra_pkg::op_t              op
);
  import bra_pkg::*;

  op_t          q_r [QDEPTH];
  logic [0:0]   wp_r, rp_r;
  logic [1:0]   cnt_r;
  op_t          cls;
  logic         push, pop;
  logic [LEN_W-1:0] start, hend;

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = op_valid && op_ready;

  always_comb begin
    start     = {1'b0, in_bit_index};
    hend      = (in_range_end > eff_len) ? eff_len : in_range_end;
    cls.cmd   = in_cmd;
    cls.lo    = start;
    cls.hi    = start + LEN_W'(1);
    cls.count = in_run_count;
    cls.align = in_align_log2;
    unique case (in_cmd)
      CMD_GET, CMD_SET, CMD_UNSET, CMD_ALLOC: ;
      CMD_FILL, CMD_CLEAR: begin
        if (start > eff_len || start > in_range_end) cls.cmd = CMD_NOP;
        else cls.hi = hend;
      end
      default: cls.cmd = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hw/rtl/bra_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_back
// Execute operations on the bitmap memory one at a time, a 32-bit word at a time.
// ----------------------------------------------------------------------------
module bra_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bra_pkg::LEN_W-1:0] eff_len,
  input  logic                      op_valid,
  output logic                      op_ready,
  input  bra_pkg::op_t              op,
  output logic                      res_valid,
  input  logic                      res_ready,
  output bra_pkg::res_t             res
);
  import bra_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_MARK = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_r;
  logic [2:0]        st_r, st_nxt;
  op_t               op_r;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  cand_r, cand_nxt;
  logic [LEN_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic              setv_r, setv_nxt;
  res_t              res_r, res_nxt;
  logic              rv_r, rv_nxt;
  logic              we;
  logic [WADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata;
  logic [LEN_W-1:0]  amask, wbase, end_c;
  logic [WBIT_W-1:0] boff;
  logic              bitv, aligned, inlen;
  logic [LEN_W:0]    need;

  assign op_ready  = (st_r == S_IDLE) && !rv_r;
  assign res_valid = rv_r;
  assign res       = res_r;

  // one bit per cycle scan; word read is registered and pos indexes within it
  assign boff  = pos_r[WBIT_W-1:0];
  assign bitv  = rdata_r[boff];
  assign amask = (op_r.align >= 4'(LEN_W)) ? '1 : ((LEN_W'(1) << op_r.align) - LEN_W'(1));
  assign aligned = (pos_r & amask) == '0;
  assign inlen = pos_r < eff_len;
  assign need  = {1'b0, cand_r} + {1'b0, op_r.count};
  assign wbase = {pos_r[LEN_W-1:WBIT_W], {WBIT_W{1'b0}}};
  assign raddr = pos_nxt[WBIT_W +: WADDR_W];

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; cand_nxt = cand_r;
    lo_nxt = lo_r; hi_nxt = hi_r; setv_nxt = setv_r;
    res_nxt = res_r; rv_nxt = rv_r;
    we = 1'b0; waddr = pos_r[WBIT_W +: WADDR_W];
    wdata = rdata_r; end_c = hi_r;
    if (rv_r && res_ready) rv_nxt = 1'b0;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1; wdata = '0;
        pos_nxt = pos_r + LEN_W'(WORD_W);
        if (pos_r[WBIT_W +: WADDR_W] == WADDR_W'(WORDS - 1)) begin
          st_nxt = S_IDLE; pos_nxt = '0;
        end
      end
      S_IDLE: begin
        if (op_valid && !rv_r) begin
          res_nxt = '0;
          pos_nxt = '0; cand_nxt = '0;
          lo_nxt = op.lo; hi_nxt = op.hi;
          setv_nxt = (op.cmd == CMD_SET) || (op.cmd == CMD_FILL);
          if (op.cmd == CMD_ALLOC) st_nxt = S_SCAN;
          else if (op.cmd == CMD_NOP) begin
            rv_nxt = 1'b1;
          end else begin
            pos_nxt = op.lo; st_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        st_nxt = S_WR;
      end
      S_WR: begin
        if (op_r.cmd == CMD_GET) begin
          res_nxt.bit_value = bitv;
          st_nxt = S_DONE;
        end else begin
          for (int b = 0; b < WORD_W; b++) begin
            if ((wbase + LEN_W'(b)) >= lo_r && (wbase + LEN_W'(b)) < end_c)
              wdata[b] = setv_r;
          end
          we = (lo_r < hi_r);
          if (wbase + LEN_W'(WORD_W) >= hi_r) st_nxt = S_DONE;
          else begin
            pos_nxt = wbase + LEN_W'(WORD_W); st_nxt = S_RD;
          end
        end
      end
      S_SCAN: begin
        // pos_r is the bit whose word rdata_r holds after the first read cycle
        if (!inlen) st_nxt = S_DONE;
        else if (pos_r != cand_r + LEN_W'(0) && bitv) begin
          cand_nxt = pos_r + LEN_W'(1); pos_nxt = pos_r + LEN_W'(1);
        end else if (pos_r == cand_r && (!aligned || bitv || need > {1'b0, eff_len}))
        begin
          cand_nxt = pos_r + LEN_W'(1); pos_nxt = pos_r + LEN_W'(1);
        end else if (need <= {1'b0, pos_r} + (LEN_W+1)'(1) || op_r.count == '0) begin
          res_nxt.found = 1'b1;
          res_nxt.alloc_index = cand_r[IDX_W-1:0];
          lo_nxt = cand_r; hi_nxt = need[LEN_W-1:0];
          setv_nxt = 1'b1;
          if (op_r.count == '0) st_nxt = S_DONE;
          else begin
            pos_nxt = cand_r; st_nxt = S_MARK;
          end
        end else pos_nxt = pos_r + LEN_W'(1);
      end
      S_MARK: begin
        st_nxt = S_RD;
      end
      S_DONE: begin
        rv_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
    if (st_r == S_IDLE && op_valid && !rv_r) op_r <= op;
    res_r <= res_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; setv_r <= setv_nxt;
    cand_r <= cand_nxt;
    if (!rst_n) begin
      st_r  <= S_CLR;
      pos_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
      rv_r  <= rv_nxt;
    end
  end
endmodule

// ===== hw/rtl/bitmap_run_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator_core
// Bitmap run allocator: get/set/unset/fill/clear/first-fit allocate.
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared one 32-bit word per cycle, during which
// requests only fill the two-entry queue. Get, set and unset read the word,
// then return the bit or write the word back; fill and clear read and write
// each 32-bit word touched; allocate scans one bit per cycle up to the used
// length and then reads and writes each word marked. A two-entry queue
// decouples request acceptance from execution; the engine holds while a
// result waits.
module bitmap_run_allocator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bra_pkg::LEN_W-1:0] cfg_used_length,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_cmd,
  input  logic [bra_pkg::IDX_W-1:0] in_bit_index,
  input  logic [bra_pkg::LEN_W-1:0] in_range_end,
  input  logic [bra_pkg::LEN_W-1:0] in_run_count,
  input  logic [3:0]                in_align_log2,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_bit_value,
  output logic [bra_pkg::IDX_W-1:0] out_alloc_index,
  output logic                      out_found
);
  import bra_pkg::*;

  logic [LEN_W-1:0] len_r, eff_len;
  logic             op_valid, op_ready;
  op_t              op;
  res_t             res;

  assign eff_len = (len_r > LEN_W'(NBITS)) ? LEN_W'(NBITS) : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= LEN_RESET;
    else if (cfg_we) len_r <= cfg_used_length;
  end

  bra_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_bit_index,
    .in_range_end, .in_run_count, .in_align_log2, .eff_len,
    .op_valid, .op_ready, .op
  );

  bra_back u_back (
    .clk, .rst_n, .eff_len, .op_valid, .op_ready, .op,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_bit_value   = res.bit_value;
  assign out_alloc_index = res.alloc_index;
  assign out_found       = res.found;
endmodule

// ===== hw/rtl/bra_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks for the bitmap run allocator.
// ----------------------------------------------------------------------------
module bra_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_bit_value,
  input logic [bra_pkg::IDX_W-1:0] out_alloc_index,
  input logic                      out_found
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("result dropped");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_alloc_index == '0)
    else $error("index without found");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_bit_value)
    else $error("found and bit both set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind bitmap_run_allocator_core bra_checker u_chk (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_run_allocator_core. A bitmap predictor runs
// beside the block and scores every result in order. Directed requests
// cover the corner cases. Random phases then follow at several used lengths,
// with bursty requests, receiver stalls, a long output hold-off and a drain.
// ----------------------------------------------------------------------------
module tb;
  import bra_pkg::*;

  class bitmap_scoreboard;
    bit          map [NBITS];
    int unsigned used_len;
    res_t        want_q[$];
    int          errors;
    int          results;

    function new();
      used_len = NBITS;
      errors   = 0;
      results  = 0;
    endfunction

    function void note_request(logic [2:0] cmd, int unsigned idx, int unsigned rend,
                               int unsigned cnt, int unsigned al);
      res_t        r;
      int unsigned len, i, j, e, mask;
      bit          ok, hit;
      idx  = idx & 32'h3FF;
      rend = rend & 32'h7FF;
      cnt  = cnt & 32'h7FF;
      al   = al & 32'hF;
      r    = '0;
      len  = (used_len > NBITS) ? NBITS : used_len;
      mask = (1 << al) - 1;
      hit  = 0;
      case (cmd)
        CMD_GET:   r.bit_value = map[idx];
        CMD_SET:   map[idx] = 1'b1;
        CMD_UNSET: map[idx] = 1'b0;
        CMD_FILL, CMD_CLEAR: begin
          if (!(idx > len || idx > rend)) begin
            e = (rend > len) ? len : rend;
            for (i = idx; i < e; i++) map[i] = (cmd == CMD_FILL);
          end
        end
        CMD_ALLOC: begin
          for (i = 0; i < len && !hit; i++) begin
            if ((i & mask) == 0 && !map[i] && cnt <= len - i) begin
              ok = 1;
              for (j = 1; j < cnt && ok; j++) if (map[i + j]) ok = 0;
              if (ok) begin
                for (j = 0; j < cnt; j++) map[i + j] = 1'b1;
                r.found       = 1'b1;
                r.alloc_index = i[IDX_W-1:0];
                hit           = 1;
              end
            end
          end
        end
        default: ;
      endcase
      want_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t w;
      results++;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      w = want_q.pop_front();
      if (w.bit_value !== got.bit_value || w.alloc_index !== got.alloc_index ||
          w.found !== got.found) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: result %0d expected bit=%0d idx=%0d found=%0d, ",
                    "got bit=%0d idx=%0d found=%0d"},
                   results, w.bit_value, w.alloc_index, w.found,
                   got.bit_value, got.alloc_index, got.found);
      end
    endfunction
  endclass

  localparam logic [2:0] CMD_RSVD = 3'd7;
  localparam int IDLE_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_used_length;
  logic             in_valid;
  logic             in_ready;
  logic [2:0]       in_cmd;
  logic [IDX_W-1:0] in_bit_index;
  logic [LEN_W-1:0] in_range_end;
  logic [LEN_W-1:0] in_run_count;
  logic [3:0]       in_align_log2;
  logic             out_valid;
  logic             out_ready;
  logic             out_bit_value;
  logic [IDX_W-1:0] out_alloc_index;
  logic             out_found;

  bitmap_scoreboard sb;
  int burst_left;
  int hold_reqs;
  int hold_done;
  int hold_cnt;
  int stall_mode;
  int idle_cycles;
  int sent;
  int phases;

  bitmap_run_allocator_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_used_length (cfg_used_length),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_bit_index    (in_bit_index),
    .in_range_end    (in_range_end),
    .in_run_count    (in_run_count),
    .in_align_log2   (in_align_log2),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_alloc_index (out_alloc_index),
    .out_found       (out_found)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: own stall pattern plus requested long hold-offs
  initial begin
    out_ready  = 1'b0;
    hold_done  = 0;
    hold_cnt   = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done++;
        hold_cnt = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready = 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready = 1'b1;
          1:       out_ready = ($urandom_range(0, 3) != 0);
          2:       out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{bit_value: out_bit_value, alloc_index: out_alloc_index,
                        found: out_found});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_req(logic [2:0] cmd, int unsigned idx, int unsigned rend,
                          int unsigned cnt, int unsigned al);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid      = 1'b1;
    in_cmd        = cmd;
    in_bit_index  = idx[IDX_W-1:0];
    in_range_end  = rend[LEN_W-1:0];
    in_run_count  = cnt[LEN_W-1:0];
    in_align_log2 = al[3:0];
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, idx, rend, cnt, al);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.want_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_length(int unsigned len);
    drain();
    repeat (20) @(negedge clk);
    cfg_we          = 1'b1;
    cfg_used_length = len[LEN_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.used_len = len;
    phases++;
  endtask

  task automatic random_req(int unsigned len);
    int unsigned le, r, s, cap;
    le  = (len > NBITS) ? NBITS : len;
    cap = (le > 16) ? 16 : le;
    r   = $urandom_range(0, 99);
    if (r < 10)
      send_req(3'($urandom_range(0, 7)), $urandom_range(0, NBITS - 1),
               $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 15));
    else if (r < 40)
      send_req(CMD_ALLOC, $urandom_range(0, NBITS - 1), $urandom_range(0, 2047),
               $urandom_range(0, cap),
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3));
    else if (r < 55) begin
      s = $urandom_range(0, (le + 2 > NBITS - 1) ? NBITS - 1 : le + 2);
      send_req($urandom_range(0, 1) ? CMD_FILL : CMD_CLEAR, s,
               ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) :
               s + $urandom_range(0, 24), $urandom_range(0, 2047), $urandom_range(0, 15));
    end else if (r < 75)
      send_req($urandom_range(0, 1) ? CMD_SET : CMD_UNSET,
               $urandom_range(0, 3) == 0 ? $urandom_range(0, NBITS - 1) :
               $urandom_range(0, (le == 0) ? 0 : le - 1),
               $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 15));
    else if (r < 97)
      send_req(CMD_GET, $urandom_range(0, (le == 0) ? 3 : le), $urandom_range(0, 2047),
               $urandom_range(0, 2047), $urandom_range(0, 15));
    else
      send_req(CMD_CLEAR, 0, 2047, 0, 0);
  endtask

  initial begin
    int unsigned lens [8] = '{64, 0, 1024, 2047, 37, 8, 200, 1};
    int          cnts [8] = '{350, 100, 120, 120, 350, 300, 250, 150};
    sb              = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_used_length = '0;
    in_valid        = 1'b0;
    in_cmd          = CMD_GET;
    in_bit_index    = '0;
    in_range_end    = '0;
    in_run_count    = '0;
    in_align_log2   = '0;
    hold_reqs       = 0;
    burst_left      = 0;
    idle_cycles     = 0;
    sent            = 0;
    phases          = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    send_req(CMD_GET, 0, 0, 0, 0);
    send_req(CMD_SET, 0, 0, 0, 0);
    send_req(CMD_GET, 0, 0, 0, 0);
    send_req(CMD_SET, 1023, 0, 0, 0);
    send_req(CMD_GET, 1023, 0, 0, 0);
    send_req(CMD_UNSET, 1023, 0, 0, 0);
    send_req(CMD_GET, 1023, 0, 0, 0);
    send_req(CMD_FILL, 10, 20, 0, 0);
    send_req(CMD_GET, 15, 0, 0, 0);
    send_req(CMD_FILL, 30, 20, 0, 0);
    send_req(CMD_CLEAR, 0, 2047, 0, 0);
    send_req(CMD_ALLOC, 0, 0, 0, 0);
    send_req(CMD_ALLOC, 0, 0, 8, 3);
    send_req(CMD_ALLOC, 0, 0, 1024, 0);
    send_req(CMD_ALLOC, 0, 0, 1, 15);
    send_req(CMD_NOP, 1023, 2047, 2047, 15);
    send_req(CMD_RSVD, 1023, 2047, 2047, 15);
    send_req(CMD_FILL, 0, 1024, 0, 0);
    send_req(CMD_ALLOC, 0, 0, 1, 0);
    send_req(CMD_CLEAR, 0, 1024, 0, 0);
    send_req(CMD_ALLOC, 0, 0, 1024, 10);
    set_length(37);
    send_req(CMD_FILL, 40, 50, 0, 0);
    send_req(CMD_SET, 500, 0, 0, 0);
    send_req(CMD_GET, 500, 0, 0, 0);
    send_req(CMD_ALLOC, 0, 0, 1, 15);

    for (int p = 0; p < 8; p++) begin
      set_length(lens[p]);
      for (int n = 0; n < cnts[p]; n++) begin
        if (n == cnts[p] / 3) begin
          // long output hold-off with the input kept busy
          hold_reqs++;
          for (int k = 0; k < 12; k++) begin
            burst_left = 2;
            random_req(lens[p]);
          end
        end
        if (n == cnts[p] / 2) drain();
        random_req(lens[p]);
      end
    end

    drain();
    repeat (50) @(negedge clk);
    $display("Ran %0d requests over %0d used-length settings, every command and corner case.",
             sent, phases);
    $display("Checked %0d results, %0d mismatches.", sb.results, sb.errors);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
